// ===== hw/rtl/clni_pkg.sv =====
// Shared types, constants and the microcode program of the character LCD nibble interface.
package clni_pkg;

    localparam int unsigned PC_W   = 5;
    localparam int unsigned HOLD_W = 15;

    // Request operation codes.
    localparam logic [2:0] FUNC_INIT    = 3'd0;
    localparam logic [2:0] FUNC_COMMAND = 3'd1;
    localparam logic [2:0] FUNC_DATA    = 3'd2;
    localparam logic [2:0] FUNC_CLEAR   = 3'd3;
    localparam logic [2:0] FUNC_CURSOR  = 3'd4;

    localparam logic [7:0] CURSOR_MASK = 8'h47;
    localparam logic [7:0] CURSOR_BASE = 8'h80;

    localparam logic [HOLD_W-1:0] PHASE_HOLD = 15'd10;
    localparam logic [HOLD_W-1:0] POWER_HOLD = 15'd20000;

    // Entry points of the program.
    localparam logic [PC_W-1:0] A_INIT   = 5'd0;
    localparam logic [PC_W-1:0] A_BYTE   = 5'd13;
    localparam logic [PC_W-1:0] A_CLEAR  = 5'd15;
    localparam logic [PC_W-1:0] A_CURSOR = 5'd19;
    localparam logic [PC_W-1:0] A_END    = 5'd20;

    localparam logic [1:0] PHASE_LAST = 2'd2;

    typedef enum logic [3:0] {
        K_WAIT   = 4'b0001,
        K_NIB    = 4'b0010,
        K_CURSOR = 4'b0100,
        K_END    = 4'b1000
    } kind_t;

    typedef enum logic [1:0] {
        NS_CONST = 2'd0,
        NS_HI    = 2'd1,
        NS_LO    = 2'd2
    } nsrc_t;

    typedef struct packed {
        kind_t             kind;
        nsrc_t             nsrc;
        logic [3:0]        nib;
        logic [HOLD_W-1:0] hold;   // hold of the final phase
        logic              last;
        logic [PC_W-1:0]   target;
    } ucode_t;

    // Control passed from the sequencer to the pin datapath.
    typedef struct packed {
        logic              fire;
        logic              rs;
        logic              is_wait;
        nsrc_t             nsrc;
        logic [3:0]        nib;
        logic [7:0]        byte_val;
        logic [1:0]        phase;
        logic [HOLD_W-1:0] hold;
        logic              last;
    } ctl_t;

    function automatic ucode_t uw(input kind_t kind, input nsrc_t nsrc, input logic [3:0] nib,
                                  input logic [HOLD_W-1:0] hold, input logic last,
                                  input logic [PC_W-1:0] target);
        ucode_t w;
        w.kind   = kind;
        w.nsrc   = nsrc;
        w.nib    = nib;
        w.hold   = hold;
        w.last   = last;
        w.target = target;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
        ucode_t w;
        case (addr)
            // Power-up: long wait, four bare nibbles, then four command bytes.
            5'd0:  w = uw(K_WAIT, NS_CONST, 4'h0, POWER_HOLD, 1'b0, A_END);
            5'd1:  w = uw(K_NIB, NS_CONST, 4'h3, 15'd5010, 1'b0, A_END);
            5'd2:  w = uw(K_NIB, NS_CONST, 4'h3, 15'd110, 1'b0, A_END);
            5'd3:  w = uw(K_NIB, NS_CONST, 4'h3, 15'd110, 1'b0, A_END);
            5'd4:  w = uw(K_NIB, NS_CONST, 4'h2, 15'd110, 1'b0, A_END);
            5'd5:  w = uw(K_NIB, NS_CONST, 4'h2, 15'd10, 1'b0, A_END);
            5'd6:  w = uw(K_NIB, NS_CONST, 4'h8, 15'd100, 1'b0, A_END);
            5'd7:  w = uw(K_NIB, NS_CONST, 4'h1, 15'd10, 1'b0, A_END);
            5'd8:  w = uw(K_NIB, NS_CONST, 4'h4, 15'd100, 1'b0, A_END);
            5'd9:  w = uw(K_NIB, NS_CONST, 4'h0, 15'd10, 1'b0, A_END);
            5'd10: w = uw(K_NIB, NS_CONST, 4'h6, 15'd100, 1'b0, A_END);
            5'd11: w = uw(K_NIB, NS_CONST, 4'h0, 15'd10, 1'b0, A_END);
            5'd12: w = uw(K_NIB, NS_CONST, 4'hC, 15'd100, 1'b1, A_END);
            // Single byte from the request register.
            5'd13: w = uw(K_NIB, NS_HI, 4'h0, 15'd10, 1'b0, A_END);
            5'd14: w = uw(K_NIB, NS_LO, 4'h0, 15'd100, 1'b1, A_END);
            // Clear display, then return home, each with the long settle time.
            5'd15: w = uw(K_NIB, NS_CONST, 4'h0, 15'd10, 1'b0, A_END);
            5'd16: w = uw(K_NIB, NS_CONST, 4'h1, 15'd1740, 1'b0, A_END);
            5'd17: w = uw(K_NIB, NS_CONST, 4'h0, 15'd10, 1'b0, A_END);
            5'd18: w = uw(K_NIB, NS_CONST, 4'h2, 15'd1740, 1'b1, A_END);
            // Cursor: test the location, then share the byte routine.
            5'd19: w = uw(K_CURSOR, NS_CONST, 4'h0, PHASE_HOLD, 1'b0, A_BYTE);
            default: w = uw(K_END, NS_CONST, 4'h0, PHASE_HOLD, 1'b1, A_END);
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] dispatch(input logic [2:0] func);
        logic [PC_W-1:0] a;
        case (func)
            FUNC_INIT:    a = A_INIT;
            FUNC_COMMAND: a = A_BYTE;
            FUNC_DATA:    a = A_BYTE;
            FUNC_CLEAR:   a = A_CLEAR;
            FUNC_CURSOR:  a = A_CURSOR;
            default:      a = A_END;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/clni_req_if.sv =====
// Request channel interface: operation code and byte.
interface clni_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

// ===== hw/rtl/clni_pin_if.sv =====
// Pin-state channel interface: one LCD pin state and its hold time.
interface clni_pin_if;
    logic        valid;
    logic        ready;
    logic        rs;
    logic        enable;
    logic [3:0]  nibble;
    logic [14:0] hold;
    logic        last;

    modport source (output valid, output rs, output enable, output nibble, output hold,
                    output last, input ready);
    modport sink (input valid, input rs, input enable, input nibble, input hold,
                  input last, output ready);
endinterface

// ===== hw/rtl/char_lcd_nibble_interface.sv =====
// Top level of the 4-bit character LCD interface: sequencer and pin datapath.
//
//  Channel  Direction  Transfer payload
//  req      in         func (3 bits), value (8 bits)
//  pins     out        rs, enable, nibble (4 bits), hold (15 bits), last
//
// The microcode sequencer issues one pin state per cycle while the pins channel is
// not stalled. A request is taken only when the previous one has issued all its
// pin states. Reset is asynchronous and clears the sequencer's busy flag, program
// counter and phase counter and output valid. A stall on pins holds the sequencer.
module char_lcd_nibble_interface (
    input  logic       clk,
    input  logic       rst_n,
    clni_req_if.sink   req,
    clni_pin_if.source pins
);

    clni_pkg::ctl_t ctl;
    logic           emit_ok;

    clni_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .emit_ok (emit_ok),
        .ctl     (ctl)
    );

    clni_pin_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .emit_ok (emit_ok),
        .pins    (pins)
    );

endmodule

// ===== hw/rtl/clni_sequencer.sv =====
// Microcode sequencer: program counter, strobe phase counter and request registers.
module clni_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    clni_req_if.sink        req,
    input  logic            emit_ok,
    output clni_pkg::ctl_t  ctl
);

    logic                      busy_reg, busy_next;
    logic [clni_pkg::PC_W-1:0] pc_reg, pc_next;
    logic [1:0]                phase_reg, phase_next;
    logic                      rs_reg, rs_next;
    logic [7:0]                byte_reg, byte_next;
    clni_pkg::ucode_t          cw;
    logic                      step_done;

    assign req.ready = !busy_reg;
    assign cw        = clni_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        busy_next  = busy_reg;
        pc_next    = pc_reg;
        phase_next = phase_reg;
        rs_next    = rs_reg;
        byte_next  = byte_reg;
        step_done  = 1'b0;

        ctl.fire     = 1'b0;
        ctl.rs       = rs_reg;
        ctl.is_wait  = (cw.kind == clni_pkg::K_WAIT);
        ctl.nsrc     = cw.nsrc;
        ctl.nib      = cw.nib;
        ctl.byte_val = byte_reg;
        ctl.phase    = phase_reg;
        ctl.hold     = cw.hold;
        ctl.last     = cw.last;

        if (!busy_reg)
        begin
            if (req.valid)
            begin
                busy_next  = 1'b1;
                pc_next    = clni_pkg::dispatch(req.func);
                phase_next = 2'd0;
                rs_next    = (req.func == clni_pkg::FUNC_DATA);
                byte_next  = req.value;
            end
        end
        else
        begin
            case (cw.kind)
                clni_pkg::K_WAIT:
                begin
                    if (emit_ok)
                    begin
                        ctl.fire  = 1'b1;
                        step_done = 1'b1;
                    end
                end
                clni_pkg::K_NIB:
                begin
                    if (emit_ok)
                    begin
                        ctl.fire = 1'b1;
                        if (phase_reg == clni_pkg::PHASE_LAST)
                        begin
                            phase_next = 2'd0;
                            step_done  = 1'b1;
                        end
                        else
                        begin
                            phase_next = phase_reg + 2'd1;
                        end
                    end
                end
                clni_pkg::K_CURSOR:
                begin
                    // A location with any masked bit set is dropped without output.
                    if ((byte_reg & clni_pkg::CURSOR_MASK) != 8'h00)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        byte_next = byte_reg + clni_pkg::CURSOR_BASE;
                        pc_next   = cw.target;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase

            if (step_done)
            begin
                if (cw.last)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    pc_next = pc_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pc_reg    <= clni_pkg::A_END;
            phase_reg <= 2'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pc_reg    <= pc_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg   <= rs_next;
        byte_reg <= byte_next;
    end

endmodule

// ===== hw/rtl/clni_pin_datapath.sv =====
// Pin datapath: forms each pin state from the control word and holds it in the output register.
module clni_pin_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  clni_pkg::ctl_t  ctl,
    output logic            emit_ok,
    clni_pin_if.source      pins
);

    logic                        valid_reg, valid_next;
    logic                        rs_reg;
    logic                        enable_reg;
    logic [3:0]                  nibble_reg;
    logic [clni_pkg::HOLD_W-1:0] hold_reg;
    logic                        last_reg;

    logic                        final_phase;
    logic [3:0]                  nib_sel;

    assign emit_ok     = !valid_reg || pins.ready;
    assign final_phase = ctl.is_wait || (ctl.phase == clni_pkg::PHASE_LAST);

    always_comb
    begin
        case (ctl.nsrc)
            clni_pkg::NS_HI: nib_sel = ctl.byte_val[7:4];
            clni_pkg::NS_LO: nib_sel = ctl.byte_val[3:0];
            default:         nib_sel = ctl.nib;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.fire)
        begin
            valid_next = 1'b1;
        end
        else if (pins.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // E is high only in the middle phase of a nibble.
    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            rs_reg     <= ctl.rs && !ctl.is_wait;
            enable_reg <= !ctl.is_wait && (ctl.phase == 2'd1);
            nibble_reg <= ctl.is_wait ? 4'h0 : nib_sel;
            hold_reg   <= final_phase ? ctl.hold : clni_pkg::PHASE_HOLD;
            last_reg   <= final_phase && ctl.last;
        end
    end

    assign pins.valid  = valid_reg;
    assign pins.rs     = rs_reg;
    assign pins.enable = enable_reg;
    assign pins.nibble = nibble_reg;
    assign pins.hold   = hold_reg;
    assign pins.last   = last_reg;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the 4-bit character LCD interface: request driver, pin-state checker.
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int MAX_IDLE        = 12;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int POWER_STEPS     = 8;

    localparam logic [clni_pkg::HOLD_W-1:0] BYTE_TAIL    = 15'd90;
    localparam logic [clni_pkg::HOLD_W-1:0] CLEAR_SETTLE = 15'd1640;
    localparam logic [clni_pkg::HOLD_W-1:0] NO_EXTRA     = 15'd0;

    localparam logic [7:0] CMD_CLEAR_DISPLAY = 8'h01;
    localparam logic [7:0] CMD_RETURN_HOME   = 8'h02;

    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    localparam logic [2:0] FUNC_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] FUNC_RESERVED_LAST  = 3'd7;

    typedef struct packed {
        logic                        rs;
        logic                        enable;
        logic [3:0]                  nibble;
        logic [clni_pkg::HOLD_W-1:0] hold;
        logic                        last;
    } pin_state_t;

    typedef struct packed {
        logic [7:0]                  code;
        logic                        is_byte;
        logic [clni_pkg::HOLD_W-1:0] extra;
    } power_step_t;

    logic clk;
    logic rst_n;

    clni_req_if req_ch ();
    clni_pin_if pin_ch ();

    char_lcd_nibble_interface dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .pins  (pin_ch)
    );

    pin_state_t expected_pins[$];

    int error_count      = 0;
    int requests_taken   = 0;
    int states_checked   = 0;
    int power_ups        = 0;
    int cursor_refused   = 0;
    int idle_cycles      = 0;
    int tx_idle_max      = 0;
    int rx_idle_max      = 0;
    bit hold_off_pending = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Power-up programme: four bare nibbles, then four command bytes.
    function automatic power_step_t power_step(input int idx);
        power_step_t s;
        case (idx)
            0:       s = '{8'h03, 1'b0, 15'd5000};
            1:       s = '{8'h03, 1'b0, 15'd100};
            2:       s = '{8'h03, 1'b0, 15'd100};
            3:       s = '{8'h02, 1'b0, 15'd100};
            4:       s = '{8'h28, 1'b1, NO_EXTRA};
            5:       s = '{8'h14, 1'b1, NO_EXTRA};
            6:       s = '{8'h06, 1'b1, NO_EXTRA};
            default: s = '{8'h0C, 1'b1, NO_EXTRA};
        endcase
        return s;
    endfunction

    function automatic void queue_phase(input logic rs, input logic enable, input logic [3:0] nib,
                                        input logic [clni_pkg::HOLD_W-1:0] hold);
        pin_state_t p;
        p = '{rs, enable, nib, hold, 1'b0};
        expected_pins.push_back(p);
    endfunction

    // Set-up, strobe high, strobe low; any extra delay lands on the final phase.
    function automatic void queue_nibble(input logic rs, input logic [3:0] nib,
                                         input logic [clni_pkg::HOLD_W-1:0] extra);
        queue_phase(rs, 1'b0, nib, clni_pkg::PHASE_HOLD);
        queue_phase(rs, 1'b1, nib, clni_pkg::PHASE_HOLD);
        queue_phase(rs, 1'b0, nib, clni_pkg::PHASE_HOLD + extra);
    endfunction

    function automatic void queue_byte(input logic rs, input logic [7:0] b,
                                       input logic [clni_pkg::HOLD_W-1:0] extra);
        queue_nibble(rs, b[7:4], NO_EXTRA);
        queue_nibble(rs, b[3:0], BYTE_TAIL + extra);
    endfunction

    function automatic void predict_pin_states(input logic [2:0] func, input logic [7:0] value);
        int          start;
        power_step_t s;
        pin_state_t  tail;
        start = expected_pins.size();
        case (func)
            clni_pkg::FUNC_INIT:
            begin
                power_ups++;
                queue_phase(RS_COMMAND, 1'b0, 4'h0, clni_pkg::POWER_HOLD);
                for (int i = 0; i < POWER_STEPS; i++)
                begin
                    s = power_step(i);
                    if (s.is_byte)
                        queue_byte(RS_COMMAND, s.code, s.extra);
                    else
                        queue_nibble(RS_COMMAND, s.code[3:0], s.extra);
                end
            end
            clni_pkg::FUNC_COMMAND: queue_byte(RS_COMMAND, value, NO_EXTRA);
            clni_pkg::FUNC_DATA:    queue_byte(RS_DATA, value, NO_EXTRA);
            clni_pkg::FUNC_CLEAR:
            begin
                queue_byte(RS_COMMAND, CMD_CLEAR_DISPLAY, CLEAR_SETTLE);
                queue_byte(RS_COMMAND, CMD_RETURN_HOME, CLEAR_SETTLE);
            end
            clni_pkg::FUNC_CURSOR:
            begin
                if ((value & clni_pkg::CURSOR_MASK) == 8'h00)
                    queue_byte(RS_COMMAND, value + clni_pkg::CURSOR_BASE, NO_EXTRA);
                else
                    cursor_refused++;
            end
            default: ;
        endcase
        if (expected_pins.size() > start)
        begin
            tail = expected_pins.pop_back();
            tail.last = 1'b1;
            expected_pins.push_back(tail);
        end
    endfunction

    // Prediction on each request transfer, comparison on each pin-state transfer, and the watchdog.
    always @(posedge clk)
    begin
        pin_state_t got;
        pin_state_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                requests_taken++;
                predict_pin_states(req_ch.func, req_ch.value);
            end
            if (pin_ch.valid && pin_ch.ready)
            begin
                got = '{pin_ch.rs, pin_ch.enable, pin_ch.nibble, pin_ch.hold, pin_ch.last};
                states_checked++;
                if (expected_pins.size() == 0)
                begin
                    $error("unexpected pin state: rs %0d enable %0d nibble %h hold %0d last %0d",
                           got.rs, got.enable, got.nibble, got.hold, got.last);
                    error_count++;
                end
                else
                begin
                    want = expected_pins.pop_front();
                    if (got.rs !== want.rs)
                    begin
                        $error("rs: expected %0d, got %0d", want.rs, got.rs);
                        error_count++;
                    end
                    if (got.enable !== want.enable)
                    begin
                        $error("enable: expected %0d, got %0d", want.enable, got.enable);
                        error_count++;
                    end
                    if (got.nibble !== want.nibble)
                    begin
                        $error("nibble: expected %h, got %h", want.nibble, got.nibble);
                        error_count++;
                    end
                    if (got.hold !== want.hold)
                    begin
                        $error("hold: expected %0d, got %0d", want.hold, got.hold);
                        error_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        error_count++;
                    end
                end
            end
            if ((req_ch.valid && req_ch.ready) || (pin_ch.valid && pin_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles, %0d pin states outstanding",
                         idle_cycles, expected_pins.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Pin-state receiver: a random pause before each transfer, plus an occasional long hold-off.
    initial
    begin
        int gap;
        pin_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_pending)
            begin
                pin_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_pending = 1'b0;
            end
            gap = $urandom_range(0, rx_idle_max);
            if (gap > 0)
            begin
                pin_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pin_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(pin_ch.valid && pin_ch.ready))
                @(posedge clk);
        end
    end

    // Valid is left high after the transfer so that back-to-back requests need no extra step.
    task automatic send_request(input logic [2:0] func, input logic [7:0] value);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= func;
        req_ch.value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_random_request();
        int         pick;
        logic [2:0] func;
        logic [7:0] value;
        pick  = $urandom_range(0, 99);
        value = 8'($urandom);
        if (pick < 5)
            func = clni_pkg::FUNC_INIT;
        else if (pick < 35)
            func = clni_pkg::FUNC_COMMAND;
        else if (pick < 65)
            func = clni_pkg::FUNC_DATA;
        else if (pick < 75)
            func = clni_pkg::FUNC_CLEAR;
        else if (pick < 92)
        begin
            func = clni_pkg::FUNC_CURSOR;
            // Most cursor locations are made legal so that the placement path is exercised.
            if (pick < 87)
                value = value & ~clni_pkg::CURSOR_MASK;
        end
        else
            func = 3'($urandom_range(FUNC_RESERVED_FIRST, FUNC_RESERVED_LAST));
        send_request(func, value);
    endtask

    task automatic wait_for_quiet();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_requests();
        tx_idle_max = 0;
        rx_idle_max = 0;
        send_request(clni_pkg::FUNC_INIT, 8'h00);
        send_request(clni_pkg::FUNC_COMMAND, 8'h00);
        send_request(clni_pkg::FUNC_COMMAND, 8'hFF);
        send_request(clni_pkg::FUNC_DATA, 8'h00);
        send_request(clni_pkg::FUNC_DATA, 8'hFF);
        send_request(clni_pkg::FUNC_DATA, 8'hA5);
        send_request(clni_pkg::FUNC_DATA, 8'h5A);
        send_request(clni_pkg::FUNC_CLEAR, 8'h00);
        // Legal cursor locations, the two highest ones wrapping past the top of the byte.
        send_request(clni_pkg::FUNC_CURSOR, 8'h00);
        send_request(clni_pkg::FUNC_CURSOR, 8'h28);
        send_request(clni_pkg::FUNC_CURSOR, 8'h80);
        send_request(clni_pkg::FUNC_CURSOR, 8'hB8);
        // Locations that fail the mask test produce nothing.
        send_request(clni_pkg::FUNC_CURSOR, 8'h01);
        send_request(clni_pkg::FUNC_CURSOR, 8'h02);
        send_request(clni_pkg::FUNC_CURSOR, 8'h04);
        send_request(clni_pkg::FUNC_CURSOR, 8'h40);
        send_request(clni_pkg::FUNC_CURSOR, 8'hFF);
        send_request(FUNC_RESERVED_FIRST, 8'hFF);
        send_request(FUNC_RESERVED_FIRST + 3'd1, 8'h00);
        send_request(FUNC_RESERVED_LAST, 8'h55);
        send_request(clni_pkg::FUNC_INIT, 8'hFF);
        send_request(clni_pkg::FUNC_CLEAR, 8'hFF);
        wait_for_quiet();
    endtask

    task automatic test_random_with_gaps();
        tx_idle_max = MAX_IDLE;
        rx_idle_max = MAX_IDLE;
        repeat (40) send_random_request();
        wait_for_quiet();
    endtask

    task automatic test_back_to_back();
        tx_idle_max = 0;
        rx_idle_max = 0;
        repeat (30) send_random_request();
        wait_for_quiet();
    endtask

    task automatic test_receiver_hold_off();
        tx_idle_max = 0;
        rx_idle_max = 3;
        hold_off_pending = 1'b1;
        repeat (30) send_random_request();
        wait_for_quiet();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= clni_pkg::FUNC_INIT;
        req_ch.value <= 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_requests();
        test_random_with_gaps();
        test_back_to_back();
        test_receiver_hold_off();

        $display("Ran %0d requests (%0d power-up sequences, %0d refused cursor moves),",
                 requests_taken, power_ups, cursor_refused);
        $display("%0d pin states checked over idle-free stretches, random gaps on both sides",
                 states_checked);
        $display("and a long receiver hold-off.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
